/* rtl/core/agc_pkg.sv */
// shared constants, codes and types for the allocation guard checker
`timescale 1ns / 1ps

package agc_pkg;

    localparam int ENTRIES_DEF     = 64;
    localparam int ADDR_BITS_DEF   = 48;
    localparam int SIZE_BITS_DEF   = 32;
    localparam int GUARD_BYTES_DEF = 8;

    localparam int GUARD_W = 64;
    localparam int CMD_W = 2;
    localparam int STATUS_W = 3;
    localparam int LIVE_W = 7;

    localparam logic [GUARD_W-1:0] GUARD_RESET = 64'hdeadbeefdeadbeef;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_STORE = 2'd2,
        CMD_EXIT  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_FREE = 3'd1,
        ST_CORRUPT  = 3'd2,
        ST_OOB      = 3'd3,
        ST_LEAK     = 3'd4,
        ST_FULL     = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

endpackage

/* rtl/core/allocation_guard_checker.sv */
// allocation guard checker: live heap block table with guard word and store checks
`timescale 1ns / 1ps

// Usage: a request is taken on a rising edge with start high and busy low; its
// result (status and live entry count) appears on status and live_count, with
// done high for exactly one cycle, and the receiver cannot stall it. The
// block table (base, size and a live flag per entry) sits in one single-port
// style synchronous memory of ENTRIES words. Alloc, free of a non-zero base and
// store check sweep the whole memory, one entry read per cycle, and busy stays
// high until the result of such a request appears, so no new request is taken
// before the sweep is through. Exit check and free of address zero touch no
// memory and answer in the next cycle, one per cycle. After reset the memory
// is cleared entry by entry with busy held high; guard pattern writes are
// taken at any time, including then.
module allocation_guard_checker #(
    parameter int ENTRIES     = agc_pkg::ENTRIES_DEF,
    parameter int ADDR_BITS   = agc_pkg::ADDR_BITS_DEF,
    parameter int SIZE_BITS   = agc_pkg::SIZE_BITS_DEF,
    parameter int GUARD_BYTES = agc_pkg::GUARD_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  agc_pkg::cmd_t                 cmd,
    input  logic [ADDR_BITS-1:0]          address,
    input  logic [SIZE_BITS-1:0]          alloc_size,
    input  logic [agc_pkg::GUARD_W-1:0]   guard_word,
    // result channel
    output logic                          done,
    output agc_pkg::status_t              status,
    output logic [agc_pkg::LIVE_W-1:0]    live_count,
    // guard pattern register
    input  logic                          guard_pattern_we,
    input  logic [agc_pkg::GUARD_W-1:0]   guard_pattern_wdata
);

    import agc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int MEM_W = 1 + ADDR_BITS + SIZE_BITS;
    localparam int CMP_W = (ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    // control state
    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  done_reg, done_next;
    status_t               status_reg, status_next;
    logic [GUARD_W-1:0]    guard_pattern_reg;
    logic [IDX_W-1:0]      clr_idx_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  issuing_reg;
    logic                  r_v_reg, r_last_reg;
    logic                  a_v_reg, a_last_reg;
    logic                  hit_reg, free_found_reg, oob_reg;

    // latched request
    cmd_t                  cmd_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [SIZE_BITS-1:0]  size_reg;
    logic [GUARD_W-1:0]    guard_reg;

    // sweep pipeline payload
    logic [IDX_W-1:0]      r_idx_reg;
    logic [IDX_W-1:0]      a_idx_reg;
    logic                  a_eq_reg, a_free_reg, a_ge_reg;
    logic [ADDR_BITS-1:0]  a_off_reg;
    logic [SIZE_BITS-1:0]  a_size_reg;
    logic [IDX_W-1:0]      hit_idx_reg, free_idx_reg;

    // table memory: {live, base, size}
    logic [MEM_W-1:0]      mem [ENTRIES];
    logic [MEM_W-1:0]      mem_rdata_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [MEM_W-1:0]      mem_wdata;
    logic                  mem_re;

    logic                  accept;
    logic                  rd_live;
    logic [ADDR_BITS-1:0]  rd_base;
    logic [SIZE_BITS-1:0]  rd_size;
    logic [CMP_W-1:0]      off_ext, size_ext;
    logic                  in_guard;

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign done       = done_reg;
    assign status     = status_reg;
    assign live_count = LIVE_W'(count_reg);

    assign mem_re  = issuing_reg;
    assign rd_live = mem_rdata_reg[MEM_W-1];
    assign rd_base = mem_rdata_reg[SIZE_BITS +: ADDR_BITS];
    assign rd_size = mem_rdata_reg[0 +: SIZE_BITS];

    // second half of the guard range test, on the registered offset
    assign off_ext  = CMP_W'(a_off_reg);
    assign size_ext = CMP_W'(a_size_reg);
    assign in_guard = a_ge_reg && (off_ext >= size_ext)
                      && ((off_ext - size_ext) < CMP_W'(GUARD_BYTES));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[rd_idx_reg];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = clr_idx_reg;
        mem_wdata   = '0;
        case (state_reg)
            S_CLEAR:
            begin
                // one entry cleared per cycle after reset
                mem_we = 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_EXIT)
                    begin
                        done_next   = 1'b1;
                        status_next = (count_reg != '0) ? ST_LEAK : ST_OK;
                    end
                    else if (cmd == CMD_FREE && address == '0)
                    begin
                        // free of the null pointer does nothing
                        done_next   = 1'b1;
                        status_next = ST_OK;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (a_v_reg && a_last_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                status_next = ST_OK;
                case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (hit_reg)
                        begin
                            // base already live: size overwritten in place
                            mem_we    = 1'b1;
                            mem_waddr = hit_idx_reg;
                            mem_wdata = {1'b1, addr_reg, size_reg};
                        end
                        else if (free_found_reg)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = free_idx_reg;
                            mem_wdata  = {1'b1, addr_reg, size_reg};
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_BAD_FREE;
                        end
                        else if (guard_reg != guard_pattern_reg)
                        begin
                            status_next = ST_CORRUPT;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = hit_idx_reg;
                            mem_wdata  = {1'b0, addr_reg, size_reg};
                            count_next = count_reg - 1'b1;
                        end
                    end
                    CMD_STORE:
                    begin
                        status_next = oob_reg ? ST_OOB : ST_OK;
                    end
                    default:
                    begin
                        status_next = (count_reg != '0) ? ST_LEAK : ST_OK;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            count_reg         <= '0;
            done_reg          <= 1'b0;
            status_reg        <= ST_OK;
            guard_pattern_reg <= GUARD_RESET;
            clr_idx_reg       <= '0;
            rd_idx_reg        <= '0;
            issuing_reg       <= 1'b0;
            r_v_reg           <= 1'b0;
            r_last_reg        <= 1'b0;
            a_v_reg           <= 1'b0;
            a_last_reg        <= 1'b0;
            hit_reg           <= 1'b0;
            free_found_reg    <= 1'b0;
            oob_reg           <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            status_reg <= status_next;

            if (guard_pattern_we)
            begin
                guard_pattern_reg <= guard_pattern_wdata;
            end

            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end

            // read issue
            if (accept && state_next == S_SCAN)
            begin
                issuing_reg    <= 1'b1;
                rd_idx_reg     <= '0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                oob_reg        <= 1'b0;
            end
            else if (issuing_reg)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
                if (rd_idx_reg == LAST_IDX)
                begin
                    issuing_reg <= 1'b0;
                end
            end

            r_v_reg    <= issuing_reg;
            r_last_reg <= issuing_reg && (rd_idx_reg == LAST_IDX);
            a_v_reg    <= r_v_reg;
            a_last_reg <= r_v_reg && r_last_reg;

            // accumulate sweep results
            if (a_v_reg)
            begin
                if (a_eq_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (a_free_reg && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                if (in_guard)
                begin
                    oob_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            addr_reg  <= address;
            size_reg  <= alloc_size;
            guard_reg <= guard_word;
        end

        r_idx_reg <= rd_idx_reg;

        // first stage of the entry test: match, free slot, offset past base
        a_idx_reg  <= r_idx_reg;
        a_eq_reg   <= rd_live && (rd_base == addr_reg);
        a_free_reg <= !rd_live;
        a_ge_reg   <= rd_live && (addr_reg >= rd_base);
        a_off_reg  <= addr_reg - rd_base;
        a_size_reg <= rd_size;

        if (a_v_reg && a_eq_reg)
        begin
            hit_idx_reg <= a_idx_reg;
        end
        if (a_v_reg && a_free_reg && !free_found_reg)
        begin
            free_idx_reg <= a_idx_reg;
        end
    end

    // the live count never goes past the table depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("live count above table depth");

    // a result only follows a finished sweep or a direct request
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg == S_FINISH) || $past(accept)))
        else $error("result strobe without a request");

    // table full is reported only when every entry is live
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_FULL) |-> (count_reg == FULL_CNT))
        else $error("table full reported with free entries");

    // no table write while the sweep is still reading
    assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
        else $error("table write during sweep");

endmodule
